>>> design/pcd_pkg.sv
`timescale 1ns / 1ps
// Package for the particle contact detection block.
// Holds default widths and fixed-point constants; no dependencies.
package pcd_pkg;

	localparam int POS_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF = 12;
	localparam int NORM_FRAC     = 14;
	localparam int NORM_W        = 16;
	localparam int THR_W         = 26;
	localparam int QUO_BITS      = NORM_FRAC + 1;

endpackage

>>> design/pcd_pair_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the contact block: particle pair, contact result, threshold write.
// Uses pcd_pkg for the normal and threshold widths.
interface pcd_pair_if #(parameter int P = 24) ();
	logic valid;
	logic ready;
	logic signed [P-1:0] left_x;
	logic signed [P-1:0] left_y;
	logic signed [P-1:0] left_z;
	logic signed [P-1:0] right_x;
	logic signed [P-1:0] right_y;
	logic signed [P-1:0] right_z;
	modport source (output valid, left_x, left_y, left_z, right_x, right_y, right_z,
		input ready);
	modport sink (input valid, left_x, left_y, left_z, right_x, right_y, right_z,
		output ready);
endinterface

interface pcd_contact_if #(parameter int P = 24) ();
	logic valid;
	logic ready;
	logic hit;
	logic signed [P-1:0] mid_x;
	logic signed [P-1:0] mid_y;
	logic signed [P-1:0] mid_z;
	logic signed [pcd_pkg::NORM_W-1:0] normal_x;
	logic signed [pcd_pkg::NORM_W-1:0] normal_y;
	logic signed [pcd_pkg::NORM_W-1:0] normal_z;
	logic [P+1:0] depth;
	modport source (output valid, hit, mid_x, mid_y, mid_z, normal_x, normal_y, normal_z,
		depth, input ready);
	modport sink (input valid, hit, mid_x, mid_y, mid_z, normal_x, normal_y, normal_z,
		depth, output ready);
endinterface

interface pcd_cfg_if ();
	logic valid;
	logic ready;
	logic [pcd_pkg::THR_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> design/particle_contact_detection.sv
`timescale 1ns / 1ps
// Contact test between two particles: distance, midpoint, unit normal, depth.
// Depends on pcd_pkg, the pcd interfaces, pcd_isqrt and pcd_div.
//
// Usage:
//   pair_in carries one particle pair per transaction (signed fixed-point positions).
//   contact_out carries one result per pair, in order: hit, midpoint, Q1.14 normal
//   pointing from right to left, and depth (the floored distance). Without a hit
//   every field but hit is zero.
//   cfg writes the contact threshold; it is always ready and is meant to be
//   written while no pair is in flight.
// Pipeline and throughput:
//   The stages are four of difference, magnitude, square and sum, one per root
//   bit of the square root, one compare stage, fifteen divider stages for the
//   normal, and the output register. One pair is accepted every cycle while no
//   result waits at contact_out.
// Reset and stalls:
//   Reset empties the pipeline and sets the threshold to 1.0. While a result
//   waits at contact_out, the whole pipeline holds; pair_in.ready drops then.
module particle_contact_detection
	import pcd_pkg::*;
#(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	pcd_pair_if.sink       pair_in,
	pcd_contact_if.source  contact_out,
	pcd_cfg_if.sink        cfg
);
	localparam int P     = POS_WIDTH;
	localparam int AW    = P + 1;
	localparam int SQ_W  = 2 * AW;
	localparam int SUM_W = (2 * P + 2 > 64) ? 64 : 2 * P + 2;
	localparam int RW    = SUM_W / 2;
	localparam int NUM_W = AW + NORM_FRAC;
	localparam int QB    = QUO_BITS;
	localparam int CMPW  = (RW > THR_W) ? RW : THR_W;
	localparam int LAT   = 4 + RW + 1 + QB + 1;

	logic [LAT-1:0] vld_q;
	logic           en;
	logic [THR_W-1:0] thr_q;

	// advance everything unless a result is stuck at the output
	assign en            = ~vld_q[LAT-1] | contact_out.ready;
	assign pair_in.ready = en;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pair_in.valid};
		end
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1) << FRAC_BITS;
		end else if (cfg.valid) begin
			thr_q <= cfg.data;
		end
	end

	logic signed [P-1:0] l_in [3];
	logic signed [P-1:0] r_in [3];
	assign l_in[0] = pair_in.left_x;
	assign l_in[1] = pair_in.left_y;
	assign l_in[2] = pair_in.left_z;
	assign r_in[0] = pair_in.right_x;
	assign r_in[1] = pair_in.right_y;
	assign r_in[2] = pair_in.right_z;

	logic signed [AW-1:0] d_s1   [3];
	logic signed [P-1:0]  mid_s1 [3];
	logic [AW-1:0]        absd_s2 [3];
	logic [2:0]           neg_s2;
	logic [P-1:0]         mid_s2 [3];
	logic [SQ_W-1:0]      sq_s3  [3];
	logic [AW-1:0]        absd_s3 [3];
	logic [2:0]           neg_s3;
	logic [P-1:0]         mid_s3 [3];
	logic [SUM_W-1:0]     sum_s4;
	logic [AW-1:0]        absd_s4 [3];
	logic [2:0]           neg_s4;
	logic [P-1:0]         mid_s4 [3];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [AW-1:0] sm;
		assign sm = AW'(l_in[a]) + AW'(r_in[a]);
		always_ff @(posedge clk) begin
			if (en) begin
				// difference and floored midpoint
				d_s1[a]    <= AW'(l_in[a]) - AW'(r_in[a]);
				mid_s1[a]  <= sm[P:1];
				// magnitude
				absd_s2[a] <= d_s1[a][AW-1] ? AW'(-d_s1[a]) : AW'(d_s1[a]);
				neg_s2[a]  <= d_s1[a][AW-1];
				mid_s2[a]  <= mid_s1[a];
				// square
				sq_s3[a]   <= absd_s2[a] * absd_s2[a];
				absd_s3[a] <= absd_s2[a];
				neg_s3[a]  <= neg_s2[a];
				mid_s3[a]  <= mid_s2[a];
				absd_s4[a] <= absd_s3[a];
				neg_s4[a]  <= neg_s3[a];
				mid_s4[a]  <= mid_s3[a];
			end
		end
	end

	// sum of squares, wrapped to the radicand width SUM_W
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= SUM_W'((SQ_W + 2)'(sq_s3[0]) + (SQ_W + 2)'(sq_s3[1])
				+ (SQ_W + 2)'(sq_s3[2]));
		end
	end

	logic [RW-1:0] root;
	pcd_isqrt #(.SUM_W(SUM_W)) u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s4),
		.root     (root)
	);

	// carry the side data alongside the root stages
	logic [AW-1:0] absd_rt_q [RW][3];
	logic [2:0]    neg_rt_q  [RW];
	logic [P-1:0]  mid_rt_q  [RW][3];

	always_ff @(posedge clk) begin
		if (en) begin
			absd_rt_q[0] <= absd_s4;
			neg_rt_q[0]  <= neg_s4;
			mid_rt_q[0]  <= mid_s4;
			for (int k = 1; k < RW; k++) begin
				absd_rt_q[k] <= absd_rt_q[k-1];
				neg_rt_q[k]  <= neg_rt_q[k-1];
				mid_rt_q[k]  <= mid_rt_q[k-1];
			end
		end
	end

	// threshold compare
	logic          hit_h;
	logic [RW-1:0] dist_h;
	logic [AW-1:0] absd_h [3];
	logic [2:0]    neg_h;
	logic [P-1:0]  mid_h  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_h  <= (CMPW'(root) <= CMPW'(thr_q));
			dist_h <= root;
			absd_h <= absd_rt_q[RW-1];
			neg_h  <= neg_rt_q[RW-1];
			mid_h  <= mid_rt_q[RW-1];
		end
	end

	logic [QB-1:0] quo [3];
	for (genvar a = 0; a < 3; a++) begin : g_div
		pcd_div #(.NUM_W(NUM_W), .DEN_W(RW), .QB(QB)) u_div (
			.clk (clk),
			.en  (en),
			.num ({absd_h[a], NORM_FRAC'(0)}),
			.den (dist_h),
			.quo (quo[a])
		);
	end

	// carry the side data alongside the divider stages
	logic          hit_dv_q  [QB];
	logic [RW-1:0] dist_dv_q [QB];
	logic [2:0]    neg_dv_q  [QB];
	logic [P-1:0]  mid_dv_q  [QB][3];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_dv_q[0]  <= hit_h;
			dist_dv_q[0] <= dist_h;
			neg_dv_q[0]  <= neg_h;
			mid_dv_q[0]  <= mid_h;
			for (int k = 1; k < QB; k++) begin
				hit_dv_q[k]  <= hit_dv_q[k-1];
				dist_dv_q[k] <= dist_dv_q[k-1];
				neg_dv_q[k]  <= neg_dv_q[k-1];
				mid_dv_q[k]  <= mid_dv_q[k-1];
			end
		end
	end

	// output register: apply sign, zero the normal at zero distance, drop on no hit
	logic                     hit_q;
	logic [P-1:0]             mid_q [3];
	logic [NORM_W-1:0]        nrm_q [3];
	logic [P+1:0]             depth_q;
	logic                     hit_o;
	logic [RW-1:0]            dist_o;

	assign hit_o  = hit_dv_q[QB-1];
	assign dist_o = dist_dv_q[QB-1];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q   <= hit_o;
			depth_q <= hit_o ? (P + 2)'(dist_o) : '0;
			for (int a = 0; a < 3; a++) begin
				mid_q[a] <= hit_o ? mid_dv_q[QB-1][a] : '0;
				if (!hit_o || dist_o == '0) begin
					nrm_q[a] <= '0;
				end else if (neg_dv_q[QB-1][a]) begin
					nrm_q[a] <= -NORM_W'(quo[a]);
				end else begin
					nrm_q[a] <= NORM_W'(quo[a]);
				end
			end
		end
	end

	assign contact_out.valid    = vld_q[LAT-1];
	assign contact_out.hit      = hit_q;
	assign contact_out.mid_x    = mid_q[0];
	assign contact_out.mid_y    = mid_q[1];
	assign contact_out.mid_z    = mid_q[2];
	assign contact_out.normal_x = nrm_q[0];
	assign contact_out.normal_y = nrm_q[1];
	assign contact_out.normal_z = nrm_q[2];
	assign contact_out.depth    = depth_q;
endmodule

>>> design/pcd_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, floor result.
// Standalone; stalls with the shared pipeline enable.
module pcd_isqrt #(
	parameter int SUM_W = 50
) (
	input  logic             clk,
	input  logic             en,
	input  logic [SUM_W-1:0] radicand,
	output logic [SUM_W/2-1:0] root
);
	localparam int RW    = SUM_W / 2;
	localparam int REM_W = RW + 3;

	logic [REM_W-1:0] rem_q  [RW];
	logic [RW-1:0]    root_q [RW];
	logic [SUM_W-1:0] rad_q  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_st
		logic [REM_W-1:0] rem_in, cat, trial;
		logic [RW-1:0]    root_in;
		logic [SUM_W-1:0] rad_in;
		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = radicand;
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
			assign rad_in  = rad_q[k-1];
		end
		// bring down the next two radicand bits and try the next root bit
		assign cat   = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (cat >= trial) begin
					rem_q[k]  <= cat - trial;
					root_q[k] <= {root_in[RW-2:0], 1'b1};
				end else begin
					rem_q[k]  <= cat;
					root_q[k] <= {root_in[RW-2:0], 1'b0};
				end
				rad_q[k] <= rad_in << 2;
			end
		end
	end

	assign root = root_q[RW-1];
endmodule

>>> design/pcd_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for a quotient known to fit QB bits, one bit per stage.
// Standalone; stalls with the shared pipeline enable.
module pcd_div #(
	parameter int NUM_W = 39,
	parameter int DEN_W = 25,
	parameter int QB    = 15
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QB-1:0]    quo
);
	localparam int CMP_W = (DEN_W + QB > NUM_W) ? DEN_W + QB : NUM_W;

	logic [CMP_W-1:0] rem_q [QB];
	logic [DEN_W-1:0] den_q [QB];
	logic [QB-1:0]    quo_q [QB];

	for (genvar k = 0; k < QB; k++) begin : g_st
		logic [CMP_W-1:0] rem_in, dsh;
		logic [DEN_W-1:0] den_in;
		logic [QB-1:0]    quo_in;
		logic             ge;
		if (k == 0) begin : g_first
			assign rem_in = CMP_W'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign quo_in = quo_q[k-1];
		end
		// compare against the divisor aligned to this quotient bit
		assign dsh = CMP_W'(den_in) << (QB - 1 - k);
		assign ge  = (rem_in >= dsh);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? rem_in - dsh : rem_in;
				den_q[k] <= den_in;
				quo_q[k] <= {quo_in[QB-2:0], ge};
			end
		end
	end

	assign quo = quo_q[QB-1];
endmodule

>>> design/pcd_chk.sv
`timescale 1ns / 1ps
// Port-level checks on the contact result channel, bound to the top level.
// Depends on pcd_pkg for the normal width.
module pcd_chk
	import pcd_pkg::*;
#(
	parameter int P = POS_WIDTH_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     hit,
	input logic [P-1:0]             mid_x,
	input logic signed [NORM_W-1:0] normal_x,
	input logic signed [NORM_W-1:0] normal_y,
	input logic signed [NORM_W-1:0] normal_z,
	input logic [P+1:0]             depth
);
	localparam logic signed [NORM_W-1:0] ONE = NORM_W'(1) << NORM_FRAC;

	// a waiting result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped under stall");

	// no hit means depth, mid_x and the normal are zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> depth == '0 && mid_x == '0 && normal_x == '0
			&& normal_y == '0 && normal_z == '0) else $error("payload on a miss");

	// a zero depth on a hit gives a zero normal
	a_zero_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit && depth == '0 |-> normal_x == '0 && normal_y == '0
			&& normal_z == '0) else $error("normal at zero distance");

	// normal components stay within one
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= ONE && normal_x >= -ONE && normal_y <= ONE
			&& normal_y >= -ONE && normal_z <= ONE && normal_z >= -ONE)
		else $error("normal out of range");
endmodule

bind particle_contact_detection pcd_chk #(.P(POS_WIDTH)) u_pcd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (contact_out.valid),
	.out_ready (contact_out.ready),
	.hit       (contact_out.hit),
	.mid_x     (contact_out.mid_x),
	.normal_x  (contact_out.normal_x),
	.normal_y  (contact_out.normal_y),
	.normal_z  (contact_out.normal_z),
	.depth     (contact_out.depth)
);
